>>> rtl/pit_pkg.sv
// Shared types and constants for the point-in-triangle test core.
// No dependencies; used by every module of the block.
package pit_pkg;

  // Stream field layout (fixed by the interface).
  localparam int unsigned FieldWidth   = 16;
  localparam int unsigned NumInFields  = 12;
  localparam int unsigned InDataWidth  = FieldWidth * NumInFields;
  localparam int unsigned OutDataWidth = 8;
  localparam int unsigned OutInsideBit = 0;
  localparam int unsigned OutDegenBit  = 1;

  // Configuration register width.
  localparam int unsigned TolWidth = 16;

  // Register stages from input acceptance to the output register.
  localparam int unsigned NumStages = 6;

  // Per-stage advance strobes, shared by all datapath modules.
  typedef struct packed {
    logic st6;
    logic st5;
    logic st4;
    logic st3;
    logic st2;
    logic st1;
  } pipe_ctrl_t;

endpackage

>>> rtl/pit_vec.sv
// Vector front end of the point-in-triangle core: stages 1 to 3.
// Differences, squares and cross products, tolerance compares.
// Depends on pit_pkg.
module pit_vec #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                               clk_i,
  input  pit_pkg::pipe_ctrl_t                ctrl_i,
  input  logic [pit_pkg::TolWidth-1:0]       tol_i,
  input  logic [pit_pkg::InDataWidth-1:0]    coord_i,
  output logic signed [2*CoordWidth+2:0]     n1_o [3],
  output logic signed [2*CoordWidth+2:0]     n2_o [3],
  output logic signed [2*CoordWidth+2:0]     n3_o [3],
  output logic                               degen_o
);

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned EW = (W > pit_pkg::FieldWidth) ? W : pit_pkg::FieldWidth;
  localparam int unsigned DW = W + 1;        // coordinate difference
  localparam int unsigned PW = 2 * W + 2;    // product of two differences
  localparam int unsigned CW = 2 * W + 3;    // cross product component
  localparam int unsigned SW = 2 * W + 4;    // squared length

  // Vector order in the square array.
  localparam int unsigned VA  = 0;
  localparam int unsigned VB  = 1;
  localparam int unsigned VC  = 2;
  localparam int unsigned VAB = 3;
  localparam int unsigned VBC = 4;

  // ---------------- stage 1: coordinate differences ----------------
  logic signed [W-1:0]  pt  [4][3];
  logic signed [DW-1:0] vec_d [5][3];
  logic signed [DW-1:0] vec_q [5][3];

  always_comb begin
    logic [EW-1:0] wide;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        wide = EW'(coord_i[(k*3+i)*pit_pkg::FieldWidth +: pit_pkg::FieldWidth]);
        pt[k][i] = $signed(wide[W-1:0]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      vec_d[VA][i]  = DW'(pt[0][i]) - DW'(pt[3][i]);
      vec_d[VB][i]  = DW'(pt[1][i]) - DW'(pt[3][i]);
      vec_d[VC][i]  = DW'(pt[2][i]) - DW'(pt[3][i]);
      vec_d[VAB][i] = DW'(pt[0][i]) - DW'(pt[1][i]);
      vec_d[VBC][i] = DW'(pt[1][i]) - DW'(pt[2][i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st1) begin
      vec_q <= vec_d;
    end
  end

  // ---------------- stage 2: products ----------------
  // Cross n1 = b x c, n2 = c x a, n3 = a x b; component i uses
  // terms u[i+1]*v[i+2] - u[i+2]*v[i+1].
  logic signed [PW-1:0] sq_d [5][3];
  logic signed [PW-1:0] sq_q [5][3];
  logic signed [PW-1:0] xp_d [3][3][2];
  logic signed [PW-1:0] xp_q [3][3][2];

  always_comb begin
    int unsigned j;
    int unsigned m;
    for (int v = 0; v < 5; v++) begin
      for (int i = 0; i < 3; i++) begin
        sq_d[v][i] = PW'(vec_q[v][i]) * PW'(vec_q[v][i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      m = (j == 2) ? 0 : j + 1;
      xp_d[0][i][0] = PW'(vec_q[VB][j]) * PW'(vec_q[VC][m]);
      xp_d[0][i][1] = PW'(vec_q[VB][m]) * PW'(vec_q[VC][j]);
      xp_d[1][i][0] = PW'(vec_q[VC][j]) * PW'(vec_q[VA][m]);
      xp_d[1][i][1] = PW'(vec_q[VC][m]) * PW'(vec_q[VA][j]);
      xp_d[2][i][0] = PW'(vec_q[VA][j]) * PW'(vec_q[VB][m]);
      xp_d[2][i][1] = PW'(vec_q[VA][m]) * PW'(vec_q[VB][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st2) begin
      sq_q <= sq_d;
      xp_q <= xp_d;
    end
  end

  // ---------------- stage 3: sums and tolerance test ----------------
  logic signed [SW-1:0] len_sq [5];
  logic [4:0]           near;
  logic signed [SW-1:0] tol_ext;
  logic signed [CW-1:0] n_d [3][3];
  logic signed [CW-1:0] n_q [3][3];
  logic                 degen_d;
  logic                 degen_q;

  assign tol_ext = SW'($signed({1'b0, tol_i}));

  always_comb begin
    for (int v = 0; v < 5; v++) begin
      len_sq[v] = SW'(sq_q[v][0]) + SW'(sq_q[v][1]) + SW'(sq_q[v][2]);
      near[v]   = (len_sq[v] <= tol_ext);
    end
    // Coincident vertices with the point off all of them.
    degen_d = near[VAB] && near[VBC] && !near[VA] && !near[VB] && !near[VC];
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        n_d[x][i] = CW'(xp_q[x][i][0]) - CW'(xp_q[x][i][1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st3) begin
      n_q     <= n_d;
      degen_q <= degen_d;
    end
  end

  assign n1_o    = n_q[0];
  assign n2_o    = n_q[1];
  assign n3_o    = n_q[2];
  assign degen_o = degen_q;

endmodule

>>> rtl/pit_dot.sv
// Same-side back end of the point-in-triangle core: stages 4 to 6.
// Split dot products of the cross vectors, sign test, result flags.
// Depends on pit_pkg.
module pit_dot #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                           clk_i,
  input  pit_pkg::pipe_ctrl_t            ctrl_i,
  input  logic signed [2*CoordWidth+2:0] n1_i [3],
  input  logic signed [2*CoordWidth+2:0] n2_i [3],
  input  logic signed [2*CoordWidth+2:0] n3_i [3],
  input  logic                           degen_i,
  output logic                           inside_o,
  output logic                           degen_o
);

  localparam int unsigned CW  = 2 * CoordWidth + 3;  // cross component
  localparam int unsigned LW  = CW / 2;              // low split width
  localparam int unsigned HW  = CW - LW;             // high split width
  localparam int unsigned PLW = CW + LW + 1;         // n1 * low part
  localparam int unsigned PHW = CW + HW;             // n1 * high part
  localparam int unsigned SLW = PLW + 2;
  localparam int unsigned SHW = PHW + 2;
  localparam int unsigned DTW = 2 * CW + 2;          // full dot product

  // ---------------- stage 4: partial products ----------------
  // Split the second operand: v = hi * 2^LW + lo, lo unsigned.
  logic signed [PLW-1:0] lo_d [2][3];
  logic signed [PHW-1:0] hi_d [2][3];
  logic signed [PLW-1:0] lo_q [2][3];
  logic signed [PHW-1:0] hi_q [2][3];
  logic                  degen4_q;

  always_comb begin
    logic signed [CW-1:0] rhs;
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 3; i++) begin
        rhs = (t == 0) ? n2_i[i] : n3_i[i];
        lo_d[t][i] = PLW'(n1_i[i]) * PLW'($signed({1'b0, rhs[LW-1:0]}));
        hi_d[t][i] = PHW'(n1_i[i]) * PHW'($signed(rhs[CW-1:LW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st4) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      degen4_q <= degen_i;
    end
  end

  // ---------------- stage 5: partial sums ----------------
  logic signed [SLW-1:0] lo_sum_d [2];
  logic signed [SHW-1:0] hi_sum_d [2];
  logic signed [SLW-1:0] lo_sum_q [2];
  logic signed [SHW-1:0] hi_sum_q [2];
  logic                  degen5_q;

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      lo_sum_d[t] = SLW'(lo_q[t][0]) + SLW'(lo_q[t][1]) + SLW'(lo_q[t][2]);
      hi_sum_d[t] = SHW'(hi_q[t][0]) + SHW'(hi_q[t][1]) + SHW'(hi_q[t][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st5) begin
      lo_sum_q <= lo_sum_d;
      hi_sum_q <= hi_sum_d;
      degen5_q <= degen4_q;
    end
  end

  // ---------------- stage 6: recombine, sign test ----------------
  logic signed [DTW-1:0] dot [2];
  logic                  inside_d;
  logic                  inside_q;
  logic                  degen6_q;

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      dot[t] = (DTW'(hi_sum_q[t]) <<< LW) + DTW'(lo_sum_q[t]);
    end
    // A zero dot product does not reject.
    inside_d = !degen5_q && !dot[0][DTW-1] && !dot[1][DTW-1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st6) begin
      inside_q <= inside_d;
      degen6_q <= degen5_q;
    end
  end

  assign inside_o = inside_q;
  assign degen_o  = degen6_q;

endmodule

>>> rtl/point_in_triangle_test_core.sv
// Point-in-triangle test core, top level: stream ports, tolerance register,
// pipeline valid/stall control. Depends on pit_pkg, pit_vec and pit_dot.
//
// Each request carries three vertices A, B, C and a point P as signed Q7.8
// coordinates (the low COORD_WIDTH bits of each 16-bit field are used). The
// core forms a=A-P, b=B-P, c=C-P and the crosses n1=bxc, n2=cxa, n3=axb,
// and reports inside unless n1.n2 or n1.n3 is negative; all arithmetic is
// exact. If |A-B|^2 and |B-C|^2 are within zero_tolerance (units of 1/65536)
// while a, b and c all exceed it, the answer is outside with the degenerate
// flag set. The core is a six-stage pipeline: it takes one request per clock
// when the output side is not stalled. The critical path is the stage-4
// partial-product multiplier (cross component times half of another
// component). A stall on the output side only squeezes out empty stages, so
// the input keeps accepting requests until every stage holds one. Write
// zero_tolerance only while no request is in flight.
module point_in_triangle_test_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: zero_tolerance.
  input  logic                                cfg_we_i,
  input  logic [pit_pkg::TolWidth-1:0]        cfg_wdata_i,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
  // vert_b_z, vert_c_x, vert_c_y, vert_c_z, point_x, point_y, point_z
  input  logic [pit_pkg::InDataWidth-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: inside_res, degenerate_reject, six zero bits
  output logic [pit_pkg::OutDataWidth-1:0]    m_axis_tdata
);

  localparam int unsigned NS = pit_pkg::NumStages;

  // Tolerance register.
  logic [pit_pkg::TolWidth-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the data; a stage advances when it is empty or
  // the stage after it advances, so bubbles collapse under a stall.
  logic [NS-1:0] valid_q;
  logic [NS-1:0] valid_d;
  logic [NS-1:0] adv;
  pit_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? s_axis_tvalid : valid_q[0];
    for (int k = 1; k < NS; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl = pit_pkg::pipe_ctrl_t'(adv);

  assign s_axis_tready = adv[0];

  // Datapath.
  logic signed [2*COORD_WIDTH+2:0] n1 [3];
  logic signed [2*COORD_WIDTH+2:0] n2 [3];
  logic signed [2*COORD_WIDTH+2:0] n3 [3];
  logic                            degen_mid;
  logic                            inside_res;
  logic                            degenerate_reject;

  pit_vec #(
    .CoordWidth (COORD_WIDTH)
  ) u_vec (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .tol_i   (tol_q),
    .coord_i (s_axis_tdata),
    .n1_o    (n1),
    .n2_o    (n2),
    .n3_o    (n3),
    .degen_o (degen_mid)
  );

  pit_dot #(
    .CoordWidth (COORD_WIDTH)
  ) u_dot (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .n1_i     (n1),
    .n2_i     (n2),
    .n3_i     (n3),
    .degen_i  (degen_mid),
    .inside_o (inside_res),
    .degen_o  (degenerate_reject)
  );

  // Output register is the last pipeline stage.
  assign m_axis_tvalid = valid_q[NS-1];

  always_comb begin
    m_axis_tdata                        = '0;
    m_axis_tdata[pit_pkg::OutInsideBit] = inside_res;
    m_axis_tdata[pit_pkg::OutDegenBit]  = degenerate_reject;
  end

  // ---------------- assertions ----------------
  // A degenerate reject never reports inside.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(inside_res && degenerate_reject))
    else $error("degenerate reject with inside set");

  // Any empty stage opens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> s_axis_tready)
    else $error("input stalled while pipeline has a free stage");

  // An accepted request occupies the first stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> valid_q[0])
    else $error("accepted request lost at stage 1");

  // A new result only comes from the stage before the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(valid_q[NS-2]))
    else $error("result appeared without a request behind it");

endmodule
